// ===== rtl/v3a_pkg.sv =====
package v3a_pkg;

    localparam int OPCODE_WIDTH = 4;
    localparam int LIMIT_WIDTH  = 23;
    localparam int SCALAR_WIDTH = 32;

    localparam logic [SCALAR_WIDTH-1:0] SCALAR_MAX = {1'b0, {(SCALAR_WIDTH-1){1'b1}}};

    typedef enum logic [OPCODE_WIDTH-1:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_SCALE = 4'd3,
        OP_ABS   = 4'd4,
        OP_DOT   = 4'd5,
        OP_MAG   = 4'd6,
        OP_DIST  = 4'd7,
        OP_CLAMP = 4'd8
    } t_opcode;

endpackage

// ===== rtl/v3a_lane.sv =====
module v3a_lane #(
    parameter int COMPONENT_WIDTH = 24
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_a,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_b,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_f,
    output logic signed [COMPONENT_WIDTH-1:0]   o_add,
    output logic signed [COMPONENT_WIDTH-1:0]   o_sub,
    output logic signed [COMPONENT_WIDTH-1:0]   o_abs,
    output logic signed [2*COMPONENT_WIDTH-1:0] o_pab,
    output logic signed [2*COMPONENT_WIDTH-1:0] o_paf,
    output logic signed [2*COMPONENT_WIDTH-1:0] o_paa,
    output logic signed [2*COMPONENT_WIDTH+1:0] o_pdd,
    output logic                                o_abig,
    output logic                                o_dbig
);
    localparam int CW = COMPONENT_WIDTH;
    localparam logic signed [CW:0] EMAX = {2'b00, {(CW-1){1'b1}}};
    localparam logic signed [CW:0] EMIN = ~EMAX;

    function automatic logic signed [CW-1:0] sat_e(input logic signed [CW:0] v);
        logic signed [CW-1:0] res;
        if (v > EMAX) begin
            res = EMAX[CW-1:0];
        end else if (v < EMIN) begin
            res = EMIN[CW-1:0];
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    logic signed [CW:0]   w_sum;
    logic signed [CW:0]   w_dif;
    logic signed [CW:0]   w_neg;
    logic signed [CW:0]   w_mag;
    logic signed [63:0]   w_a64;
    logic signed [63:0]   w_d64;

    assign w_sum = (CW+1)'(i_a) + (CW+1)'(i_b);
    assign w_dif = (CW+1)'(i_a) - (CW+1)'(i_b);
    assign w_neg = -(CW+1)'(i_a);
    assign w_mag = i_a[CW-1] ? w_neg : (CW+1)'(i_a);
    assign w_a64 = 64'(i_a);
    assign w_d64 = 64'(w_dif);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_add  <= sat_e(w_sum);
            o_sub  <= sat_e(w_dif);
            o_abs  <= sat_e(w_mag);
            o_pab  <= i_a * i_b;
            o_paf  <= i_a * i_f;
            o_paa  <= i_a * i_a;
            o_pdd  <= w_dif * w_dif;
            // A component of 2^31 or more in size pins the norm to the scalar maximum.
            o_abig <= (w_a64 >= 64'sh8000_0000) || (w_a64 <= -64'sh8000_0000);
            o_dbig <= (w_d64 >= 64'sh8000_0000) || (w_d64 <= -64'sh8000_0000);
        end
    end

endmodule

// ===== rtl/v3a_merge.sv =====
module v3a_merge #(
    parameter int COMPONENT_WIDTH = 24,
    parameter int FRACTION_BITS   = 12
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [v3a_pkg::OPCODE_WIDTH-1:0]    i_op,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_add [3],
    input  logic signed [COMPONENT_WIDTH-1:0]   i_sub [3],
    input  logic signed [COMPONENT_WIDTH-1:0]   i_abs [3],
    input  logic signed [2*COMPONENT_WIDTH-1:0] i_pab [3],
    input  logic signed [2*COMPONENT_WIDTH-1:0] i_paf [3],
    input  logic signed [2*COMPONENT_WIDTH-1:0] i_paa [3],
    input  logic signed [2*COMPONENT_WIDTH+1:0] i_pdd [3],
    input  logic [2:0]                          i_abig,
    input  logic [2:0]                          i_dbig,
    output logic signed [COMPONENT_WIDTH-1:0]   o_vec [3],
    output logic [v3a_pkg::SCALAR_WIDTH-1:0]    o_dot,
    output logic [2*COMPONENT_WIDTH+1:0]        o_sq,
    output logic                                o_nsat
);
    import v3a_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int PW = 2*CW + 2;
    localparam int XW = (PW > SCALAR_WIDTH + 1) ? PW : SCALAR_WIDTH + 1;
    localparam logic signed [PW-1:0] CMAX = {{(CW+3){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [PW-1:0] CMIN = ~CMAX;
    localparam logic signed [XW-1:0] SMAX = {{(XW-SCALAR_WIDTH+1){1'b0}}, {(SCALAR_WIDTH-1){1'b1}}};
    localparam logic signed [XW-1:0] SMIN = ~SMAX;

    function automatic logic signed [CW-1:0] sat_c(input logic signed [PW-1:0] v);
        logic signed [CW-1:0] res;
        if (v > CMAX) begin
            res = CMAX[CW-1:0];
        end else if (v < CMIN) begin
            res = CMIN[CW-1:0];
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    logic signed [PW-1:0]           w_dsum;
    logic signed [XW-1:0]           w_dext;
    logic [SCALAR_WIDTH-1:0]        w_dot;
    logic [PW-1:0]                  w_sqa;
    logic [PW-1:0]                  w_sqd;
    logic signed [CW-1:0]           w_vec [3];

    // The exact sum of the products, floored once, equals the sum of floored parts plus carries.
    assign w_dsum = PW'(i_pab[0]) + PW'(i_pab[1]) + PW'(i_pab[2]);
    assign w_dext = XW'(w_dsum >>> FRACTION_BITS);
    assign w_sqa  = PW'(unsigned'(i_paa[0])) + PW'(unsigned'(i_paa[1]))
                  + PW'(unsigned'(i_paa[2]));
    assign w_sqd  = unsigned'(i_pdd[0]) + unsigned'(i_pdd[1]) + unsigned'(i_pdd[2]);

    always_comb begin
        if (w_dext > SMAX) begin
            w_dot = SMAX[SCALAR_WIDTH-1:0];
        end else if (w_dext < SMIN) begin
            w_dot = SMIN[SCALAR_WIDTH-1:0];
        end else begin
            w_dot = w_dext[SCALAR_WIDTH-1:0];
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_vec
        always_comb begin
            unique case (i_op)
                OP_ADD:   w_vec[i] = i_add[i];
                OP_SUB:   w_vec[i] = i_sub[i];
                OP_MUL:   w_vec[i] = sat_c(PW'(i_pab[i] >>> FRACTION_BITS));
                OP_SCALE: w_vec[i] = sat_c(PW'(i_paf[i] >>> FRACTION_BITS));
                OP_ABS:   w_vec[i] = i_abs[i];
                default:  w_vec[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                o_vec[k] <= w_vec[k];
            end
            o_dot  <= (i_op == OP_DOT) ? w_dot : '0;
            o_sq   <= (i_op == OP_DIST) ? w_sqd : w_sqa;
            o_nsat <= (i_op == OP_DIST) ? (|i_dbig) : (|i_abig);
        end
    end

endmodule

// ===== rtl/v3a_sqrt.sv =====
module v3a_sqrt #(
    parameter int IN_WIDTH = 50
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [IN_WIDTH-1:0]   i_x,
    output logic [IN_WIDTH/2-1:0] o_root
);
    localparam int IW = IN_WIDTH;
    localparam int OW = IN_WIDTH / 2;

    logic [IW-1:0] r_x   [OW-1];
    logic [OW+1:0] r_rem [OW-1];
    logic [OW-1:0] r_q   [OW];

    // One root bit per stage: bring down two radicand bits, try (2q)*2+1.
    for (genvar i = 0; i < OW; i++) begin : g_stage
        logic [IW-1:0] w_x;
        logic [OW+1:0] w_rem;
        logic [OW-1:0] w_q;
        logic [OW+1:0] w_cur;
        logic [OW+1:0] w_trial;
        logic          w_fit;

        if (i == 0) begin : g_first
            assign w_x   = i_x;
            assign w_rem = '0;
            assign w_q   = '0;
        end else begin : g_next
            assign w_x   = r_x[i-1];
            assign w_rem = r_rem[i-1];
            assign w_q   = r_q[i-1];
        end

        assign w_cur   = {w_rem[OW-1:0], w_x[IW-1 -: 2]};
        assign w_trial = {w_q, 2'b01};
        assign w_fit   = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[i] <= {w_q[OW-2:0], w_fit};
            end
        end

        if (i < OW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[i]   <= w_x << 2;
                    r_rem[i] <= w_fit ? (w_cur - w_trial) : w_cur;
                end
            end
        end
    end

    assign o_root = r_q[OW-1];

endmodule

// ===== rtl/v3a_div.sv =====
module v3a_div #(
    parameter int NUM_WIDTH = 47,
    parameter int DEN_WIDTH = 25,
    parameter int QUO_WIDTH = 24
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [NUM_WIDTH-1:0] i_num,
    input  logic [DEN_WIDTH-1:0] i_den,
    output logic [QUO_WIDTH-1:0] o_q
);
    localparam int NW = NUM_WIDTH;
    localparam int DW = DEN_WIDTH;
    localparam int QW = QUO_WIDTH;

    logic [DW-1:0] r_rem [QW-1];
    logic [QW-1:0] r_lo  [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_q   [QW];

    // The caller guarantees num < den * 2^QW, so the top part starts below den.
    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [DW-1:0] w_rem;
        logic [QW-1:0] w_lo;
        logic [DW-1:0] w_den;
        logic [QW-1:0] w_q;
        logic [DW:0]   w_cur;
        logic [DW:0]   w_sub;
        logic          w_fit;

        if (i == 0) begin : g_first
            assign w_rem = DW'(i_num[NW-1:QW]);
            assign w_lo  = i_num[QW-1:0];
            assign w_den = i_den;
            assign w_q   = '0;
        end else begin : g_next
            assign w_rem = r_rem[i-1];
            assign w_lo  = r_lo[i-1];
            assign w_den = r_den[i-1];
            assign w_q   = r_q[i-1];
        end

        assign w_cur = {w_rem, w_lo[QW-1]};
        assign w_sub = w_cur - {1'b0, w_den};
        assign w_fit = (w_cur >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[i] <= {w_q[QW-2:0], w_fit};
            end
        end

        if (i < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[i] <= w_fit ? w_sub[DW-1:0] : w_cur[DW-1:0];
                    r_lo[i]  <= w_lo << 1;
                    r_den[i] <= w_den;
                end
            end
        end
    end

    assign o_q = r_q[QW-1];

endmodule

// ===== rtl/vec3_vector_alu.sv =====
// Three-component fixed-point vector unit, one request in, one result out.
// Input stream (s side): a request carries opcode, vectors a and b, a scale
// factor and a clamp limit, packed into i_s_tdata from the lowest bit up.
// Output stream (m side): result vector rx, ry, rz and scalar_out.
// Vector opcodes leave scalar_out at zero; scalar opcodes leave the vector
// at zero; opcodes 9 to 15 give an all-zero result.
// Throughput: one request per cycle, no gaps between requests, while no stall holds the pipeline.
// Path: from acceptance to o_m_tvalid a request passes the input register,
// the lane and merge registers, the square-root pipeline (one root bit
// per stage), the clamp preparation register and the clamp divider pipeline
// (one quotient bit per stage); every other opcode rides along beside them.
// Stalls: the whole pipeline holds while the output register is full and
// i_m_tready is low; o_s_tready then drops in the same cycle, so a result
// is never dropped and no request is lost.
// Reset (i_rst_n low, synchronous) empties every pipeline stage; there is
// no other state, and the block is ready in the first cycle after reset.
module vec3_vector_alu #(
    parameter int COMPONENT_WIDTH = 24,
    parameter int FRACTION_BITS   = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // opcode, ax, ay, az, bx, by_comp, bz, factor, limit; zero padded
    input  logic [((4+7*COMPONENT_WIDTH+23+7)/8)*8-1:0] i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // rx, ry, rz, scalar_out; zero padded
    output logic [((3*COMPONENT_WIDTH+32+7)/8)*8-1:0] o_m_tdata
);
    import v3a_pkg::*;

    localparam int CW    = COMPONENT_WIDTH;
    localparam int SQW   = 2*CW + 2;
    localparam int OW    = CW + 1;
    localparam int MW    = (OW > LIMIT_WIDTH) ? OW : LIMIT_WIDTH;
    localparam int NW    = CW + LIMIT_WIDTH;
    localparam int IN_W  = ((OPCODE_WIDTH + 7*CW + LIMIT_WIDTH + 7) / 8) * 8;
    localparam int OUT_W = ((3*CW + SCALAR_WIDTH + 7) / 8) * 8;
    localparam int OUT_BITS = 3*CW + SCALAR_WIDTH;

    typedef struct packed {
        logic [OPCODE_WIDTH-1:0] op;
        logic [2:0][CW-1:0]      vec;
        logic [SCALAR_WIDTH-1:0] dot;
        logic                    nsat;
        logic [2:0][CW-1:0]      a;
        logic [LIMIT_WIDTH-1:0]  lim;
    } t_side;

    typedef struct packed {
        logic [OPCODE_WIDTH-1:0] op;
        logic [2:0][CW-1:0]      vec;
        logic [SCALAR_WIDTH-1:0] scalar;
        logic [2:0][CW-1:0]      a;
        logic                    clip;
    } t_tail;

    logic w_adv;

    // Input register.
    logic                          r0_valid;
    logic [OPCODE_WIDTH-1:0]       r0_op;
    logic signed [CW-1:0]          r0_a [3];
    logic signed [CW-1:0]          r0_b [3];
    logic signed [CW-1:0]          r0_f;
    logic [LIMIT_WIDTH-1:0]        r0_lim;

    // Lane outputs.
    logic signed [CW-1:0]          w_add [3];
    logic signed [CW-1:0]          w_sub [3];
    logic signed [CW-1:0]          w_abs [3];
    logic signed [2*CW-1:0]        w_pab [3];
    logic signed [2*CW-1:0]        w_paf [3];
    logic signed [2*CW-1:0]        w_paa [3];
    logic signed [2*CW+1:0]        w_pdd [3];
    logic [2:0]                    w_abig;
    logic [2:0]                    w_dbig;
    logic                          r1_valid;
    logic [OPCODE_WIDTH-1:0]       r1_op;
    logic [2:0][CW-1:0]            r1_a;
    logic [LIMIT_WIDTH-1:0]        r1_lim;

    // Merge outputs.
    logic signed [CW-1:0]          w_mvec [3];
    logic [SCALAR_WIDTH-1:0]       w_mdot;
    logic [SQW-1:0]                w_msq;
    logic                          w_mnsat;
    logic                          r2_valid;
    logic [OPCODE_WIDTH-1:0]       r2_op;
    logic [2:0][CW-1:0]            r2_a;
    logic [LIMIT_WIDTH-1:0]        r2_lim;
    t_side                         w_side;

    // Side line beside the root pipeline.
    t_side                         r_sd [OW];
    logic [OW-1:0]                 r_sv;
    logic [OW-1:0]                 w_root;
    t_side                         w_st;
    logic                          w_root_big;

    // Clamp preparation stage.
    logic                          r3_valid;
    t_tail                         r3_tail;
    logic [NW-1:0]                 r3_num [3];
    logic [OW-1:0]                 r3_den;
    logic [CW-1:0]                 w_amag [3];
    t_tail                         w_tail;

    // Side line beside the divider.
    t_tail                         r_dd [CW];
    logic [CW-1:0]                 r_dv;
    logic [CW-1:0]                 w_q [3];
    t_tail                         w_ft;
    logic [2:0][CW-1:0]            w_res;

    // Output register.
    logic                          r_out_valid;
    logic [OUT_BITS-1:0]           r_out_data;

    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = w_adv;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_out_data);

    // Stage 0: capture the request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_adv) begin
            r0_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_op <= i_s_tdata[OPCODE_WIDTH-1:0];
            for (int k = 0; k < 3; k++) begin
                r0_a[k] <= i_s_tdata[OPCODE_WIDTH + k*CW +: CW];
                r0_b[k] <= i_s_tdata[OPCODE_WIDTH + (3+k)*CW +: CW];
            end
            r0_f   <= i_s_tdata[OPCODE_WIDTH + 6*CW +: CW];
            r0_lim <= i_s_tdata[OPCODE_WIDTH + 7*CW +: LIMIT_WIDTH];
        end
    end

    // Stage 1: one lane per component.
    for (genvar i = 0; i < 3; i++) begin : g_lane
        v3a_lane #(
            .COMPONENT_WIDTH (CW)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_a    (r0_a[i]),
            .i_b    (r0_b[i]),
            .i_f    (r0_f),
            .o_add  (w_add[i]),
            .o_sub  (w_sub[i]),
            .o_abs  (w_abs[i]),
            .o_pab  (w_pab[i]),
            .o_paf  (w_paf[i]),
            .o_paa  (w_paa[i]),
            .o_pdd  (w_pdd[i]),
            .o_abig (w_abig[i]),
            .o_dbig (w_dbig[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_op  <= r0_op;
            r1_lim <= r0_lim;
            for (int k = 0; k < 3; k++) begin
                r1_a[k] <= r0_a[k];
            end
            r2_op  <= r1_op;
            r2_a   <= r1_a;
            r2_lim <= r1_lim;
        end
    end

    // Stage 2: combine the lanes.
    v3a_merge #(
        .COMPONENT_WIDTH (CW),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_merge (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_op   (r1_op),
        .i_add  (w_add),
        .i_sub  (w_sub),
        .i_abs  (w_abs),
        .i_pab  (w_pab),
        .i_paf  (w_paf),
        .i_paa  (w_paa),
        .i_pdd  (w_pdd),
        .i_abig (w_abig),
        .i_dbig (w_dbig),
        .o_vec  (w_mvec),
        .o_dot  (w_mdot),
        .o_sq   (w_msq),
        .o_nsat (w_mnsat)
    );

    always_comb begin
        w_side.op   = r2_op;
        for (int k = 0; k < 3; k++) begin
            w_side.vec[k] = w_mvec[k];
        end
        w_side.dot  = w_mdot;
        w_side.nsat = w_mnsat;
        w_side.a    = r2_a;
        w_side.lim  = r2_lim;
    end

    v3a_sqrt #(
        .IN_WIDTH (SQW)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_x    (w_msq),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
        end else if (w_adv) begin
            r_sv <= {r_sv[OW-2:0], r2_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sd[0] <= w_side;
            for (int k = 1; k < OW; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // Stage 3: pick the scalar, decide whether clamp scales, form |a|*limit.
    assign w_st       = r_sd[OW-1];
    assign w_root_big = |(MW'(w_root) >> (SCALAR_WIDTH - 1));

    always_comb begin
        w_tail.op  = w_st.op;
        w_tail.vec = w_st.vec;
        w_tail.a   = w_st.a;
        w_tail.clip = (w_st.op == OP_CLAMP) && (MW'(w_root) > MW'(w_st.lim));
        if (w_st.op == OP_MAG || w_st.op == OP_DIST) begin
            w_tail.scalar = (w_st.nsat || w_root_big) ? SCALAR_MAX : SCALAR_WIDTH'(w_root);
        end else begin
            w_tail.scalar = w_st.dot;
        end
        for (int k = 0; k < 3; k++) begin
            w_amag[k] = w_st.a[k][CW-1] ? CW'(-w_st.a[k]) : w_st.a[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_adv) begin
            r3_valid <= r_sv[OW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_tail <= w_tail;
            r3_den  <= w_root;
            for (int k = 0; k < 3; k++) begin
                r3_num[k] <= NW'(w_amag[k]) * NW'(w_st.lim);
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        v3a_div #(
            .NUM_WIDTH (NW),
            .DEN_WIDTH (OW),
            .QUO_WIDTH (CW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_num (r3_num[i]),
            .i_den (r3_den),
            .o_q   (w_q[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (w_adv) begin
            r_dv <= {r_dv[CW-2:0], r3_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dd[0] <= r3_tail;
            for (int k = 1; k < CW; k++) begin
                r_dd[k] <= r_dd[k-1];
            end
        end
    end

    // Final selection: clamp takes the signed quotient or a unchanged; other opcodes pass their vector.
    assign w_ft = r_dd[CW-1];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (w_ft.op == OP_CLAMP) begin
                if (w_ft.clip) begin
                    w_res[k] = w_ft.a[k][CW-1] ? CW'(-w_q[k]) : w_q[k];
                end else begin
                    w_res[k] = w_ft.a[k];
                end
            end else begin
                w_res[k] = w_ft.vec[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_dv[CW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {w_ft.scalar, w_res[2], w_res[1], w_res[0]};
        end
    end

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r0_valid && w_adv |=> r1_valid)
        else $error("request lost between input register and lanes");

    a_quotient_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[CW-1] && w_ft.clip |-> !(w_q[0][CW-1] || w_q[1][CW-1] || w_q[2][CW-1]))
        else $error("clamp quotient out of component range");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |-> !o_s_tready)
        else $error("request taken while result is stalled");

    a_clip_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[CW-1] && w_ft.clip |-> (w_ft.scalar == '0))
        else $error("clamp result carries a scalar");

endmodule
